/* rtl/core/tmp_pkg.sv */
// Shared constants for the trapezoidal motion profile unit.
package tmp_pkg;

	localparam int POS_W = 32;
	localparam int LIM_W = 31;
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 32;
	localparam int ROOT_W = 32;
	localparam int RAD_W = 2 * ROOT_W;

	localparam logic [LIM_W-1:0] MIN_LIMIT = 31'd66;
	localparam logic [LIM_W-1:0] MAX_VEL_RESET = 31'd6553600;
	localparam logic [LIM_W-1:0] MAX_ACC_RESET = 31'd13107200;
	localparam logic [POS_W-1:0] TICK_MS = 32'd1;
	localparam logic [DIV_DEN_W-1:0] MS_PER_S = 32'd1000;

	// Elapsed seconds in Q16.16 grow by this whole step and fraction per tick.
	localparam logic [POS_W:0] E_STEP = (POS_W+1)'((32'd65536 * TICK_MS) / MS_PER_S);
	localparam logic [9:0] E_FRAC = 10'((32'd65536 * TICK_MS) % MS_PER_S);

	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic REG_MAX_VEL = 1'b0;
	localparam logic REG_MAX_ACC = 1'b1;

endpackage

/* rtl/core/tmp_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module tmp_div import tmp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   sh;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign sh = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
			cnt_q <= CNT_W'(DIV_NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : sh[DIV_DEN_W-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

/* rtl/core/tmp_sqrt.sv */
// Integer square root that produces one root bit per cycle.
module tmp_sqrt import tmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+2:0] sh;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] diff;
	logic              ge;

	assign sh = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff = sh - trial;
	assign ge = sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rad_q <= rad;
			rem_q <= '0;
			root_q <= '0;
			cnt_q <= CNT_W'(ROOT_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q <= ge ? diff[ROOT_W:0] : sh[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/core/trapezoidal_motion_profile_unit.sv */
// Top level of the trapezoidal motion profile unit: sequencer, shared multiplier and state.
//
// The input channel (in_valid/in_ready) carries one transaction per command: cmd 0 starts
// a move from start_position to target_position, cmd 1 is a one millisecond tick. Every
// input transaction yields exactly one output transaction (out_valid/out_ready) with the
// profiled position, the latched target and the finished flag.
// One item is handled at a time; in_ready is high only while the unit is idle.
// Elapsed seconds are a running sum grown on every tick by a step plus a fraction carry.
// A tick presents its result after the phase decision and up to three passes through the
// shared multiplier during deceleration; a tick while finished presents its result on the
// cycle after acceptance.
// A move presents its result after one or two square roots and up to three divisions run
// through the shared units; a very short move presents its result on the cycle after
// acceptance.
// The result holds on the output until out_ready is seen; a stalled receiver stalls input.
// Limit registers are written through cfg_wr_en/cfg_index/cfg_data and are raised to a
// minimum of 0.001. Reset restores the default limits and leaves the unit finished at zero.
module trapezoidal_motion_profile_unit import tmp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [POS_W-1:0] start_position,
	input  logic [POS_W-1:0] target_position,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [POS_W-1:0] current_position,
	output logic [POS_W-1:0] target_now,
	output logic             finished,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [LIM_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_M_MUL1, ST_M_SQ, ST_DV_RT, ST_M_MUL2, ST_DV_RD, ST_M_CMP,
		ST_M_MUL3, ST_DV_CT, ST_M_WHOLE, ST_T_PH, ST_T_VT, ST_T_HA1,
		ST_T_HA2, ST_T_POS, ST_T_FIN, ST_OUT
	} state_t;

	typedef enum logic [1:0] {PH_ACC, PH_CRU, PH_DEC} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [LIM_W-1:0] maxv_q;
	logic [LIM_W-1:0] maxa_q;
	logic [POS_W-1:0] origin_q;
	logic [POS_W-1:0] goal_q;
	logic [POS_W-1:0] present_q;
	logic             neg_q;
	logic [POS_W-1:0] elapsed_q;
	logic [POS_W-1:0] total_q;
	logic [POS_W-1:0] ramp_d_q;
	logic [POS_W-1:0] coast_d_q;
	logic [POS_W-1:0] peak_q;
	logic [POS_W-1:0] ramp_t_q;
	logic [POS_W-1:0] coast_t_q;
	logic [POS_W-1:0] whole_t_q;
	logic             done_q;
	logic             second_q;
	logic [63:0]      prod_q;
	logic [POS_W:0]   e_q;
	logic [9:0]       efrac_q;
	logic [POS_W-1:0] x_q;
	logic [47:0]      vt_q;
	logic [POS_W-1:0] v_q;
	logic [46:0]      h_q;
	logic [POS_W-1:0] d_q;
	logic             div_start_q;
	logic             sq_start_q;

	logic [LIM_W-1:0]     cfg_val;
	logic signed [POS_W:0] diff;
	logic [POS_W:0]       dist_abs;
	logic [POS_W:0]       elapsed_sum;
	logic [10:0]          frac_sum;
	logic                 frac_wrap;
	logic [POS_W:0]       e_sum;
	logic [POS_W-1:0]     mul_a;
	logic [POS_W-1:0]     mul_b;
	logic [63:0]          product;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [POS_W-1:0]     div_sat;
	logic                 sq_done;
	logic [ROOT_W-1:0]    sq_root;
	logic [POS_W:0]       e_after_ramp;
	logic [POS_W+1:0]     whole_sum;
	logic signed [50:0]   pos;

	assign cfg_val = (cfg_data < MIN_LIMIT) ? MIN_LIMIT : cfg_data;
	assign diff = $signed({target_position[POS_W-1], target_position})
		- $signed({start_position[POS_W-1], start_position});
	assign dist_abs = diff[POS_W] ? (~diff + 1'b1) : diff;
	assign elapsed_sum = {1'b0, elapsed_q} + {1'b0, TICK_MS};
	assign frac_sum = {1'b0, efrac_q} + {1'b0, E_FRAC};
	assign frac_wrap = (frac_sum >= 11'(MS_PER_S));
	assign e_sum = {1'b0, e_q[POS_W-1:0]} + E_STEP + {{POS_W{1'b0}}, frac_wrap};
	assign e_after_ramp = e_q - {1'b0, ramp_t_q};
	assign whole_sum = {2'b00, ramp_t_q} + {2'b00, ramp_t_q} + {2'b00, coast_t_q};
	assign div_sat = (|div_quo[DIV_NUM_W-1:POS_W]) ? '1 : div_quo[POS_W-1:0];

	always_comb begin
		case (state_q)
			ST_M_MUL1: begin mul_a = total_q; mul_b = {1'b0, maxa_q}; end
			ST_M_MUL2: begin mul_a = peak_q; mul_b = peak_q; end
			ST_M_MUL3: begin mul_a = {maxa_q, 1'b0}; mul_b = ramp_d_q; end
			ST_T_VT: begin mul_a = peak_q; mul_b = x_q; end
			ST_T_HA1: begin mul_a = {1'b0, maxa_q}; mul_b = x_q; end
			ST_T_HA2: begin mul_a = v_q; mul_b = x_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign product = mul_a * mul_b;

	always_comb begin
		case (state_q)
			ST_DV_RT: begin
				div_num = {16'd0, peak_q, 16'd0};
				div_den = {1'b0, maxa_q};
			end
			ST_DV_RD: begin
				div_num = prod_q;
				div_den = {maxa_q, 1'b0};
			end
			ST_DV_CT: begin
				div_num = {16'd0, coast_d_q, 16'd0};
				div_den = peak_q;
			end
			default: begin
				div_num = '0;
				div_den = MS_PER_S;
			end
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_ACC: pos = $signed(51'(h_q));
			PH_CRU: pos = $signed(51'(ramp_d_q) + 51'(vt_q));
			default: pos = $signed(51'(ramp_d_q) + 51'(coast_d_q) + 51'(vt_q) - 51'(h_q));
		endcase
	end

	tmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	tmp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.rad    (prod_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_ACC;
			maxv_q <= MAX_VEL_RESET;
			maxa_q <= MAX_ACC_RESET;
			origin_q <= '0;
			goal_q <= '0;
			present_q <= '0;
			neg_q <= 1'b0;
			elapsed_q <= '0;
			total_q <= '0;
			ramp_d_q <= '0;
			coast_d_q <= '0;
			peak_q <= '0;
			ramp_t_q <= '0;
			coast_t_q <= '0;
			whole_t_q <= '0;
			done_q <= 1'b1;
			second_q <= 1'b0;
			prod_q <= '0;
			e_q <= '0;
			efrac_q <= '0;
			x_q <= '0;
			vt_q <= '0;
			v_q <= '0;
			h_q <= '0;
			d_q <= '0;
			div_start_q <= 1'b0;
			sq_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			sq_start_q <= 1'b0;
			if (cfg_wr_en) begin
				if (cfg_index == REG_MAX_VEL) begin
					maxv_q <= cfg_val;
				end else begin
					maxa_q <= cfg_val;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cmd == CMD_MOVE) begin
							origin_q <= start_position;
							goal_q <= target_position;
							elapsed_q <= '0;
							e_q <= '0;
							efrac_q <= '0;
							neg_q <= diff[POS_W];
							total_q <= dist_abs[POS_W-1:0];
							second_q <= 1'b0;
							if (dist_abs < (POS_W+1)'(MIN_LIMIT)) begin
								ramp_d_q <= '0;
								coast_d_q <= '0;
								peak_q <= '0;
								ramp_t_q <= '0;
								coast_t_q <= '0;
								whole_t_q <= '0;
								present_q <= target_position;
								done_q <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								present_q <= start_position;
								state_q <= ST_M_MUL1;
							end
						end else begin
							elapsed_q <= elapsed_sum[POS_W] ? '1 : elapsed_sum[POS_W-1:0];
							efrac_q <= frac_wrap ? 10'(frac_sum - 11'(MS_PER_S)) : frac_sum[9:0];
							e_q <= e_q[POS_W] ? e_q : e_sum;
							if (done_q) begin
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_T_PH;
							end
						end
					end
				end
				ST_M_MUL1: begin
					prod_q <= product;
					sq_start_q <= 1'b1;
					state_q <= ST_M_SQ;
				end
				ST_M_SQ: begin
					if (sq_done) begin
						if (second_q || sq_root < {1'b0, maxv_q}) begin
							peak_q <= sq_root;
						end else begin
							peak_q <= {1'b0, maxv_q};
						end
						div_start_q <= 1'b1;
						state_q <= ST_DV_RT;
					end
				end
				ST_DV_RT: begin
					if (div_done) begin
						ramp_t_q <= div_sat;
						state_q <= second_q ? ST_M_WHOLE : ST_M_MUL2;
					end
				end
				ST_M_MUL2: begin
					prod_q <= product;
					div_start_q <= 1'b1;
					state_q <= ST_DV_RD;
				end
				ST_DV_RD: begin
					if (div_done) begin
						ramp_d_q <= div_sat;
						state_q <= ST_M_CMP;
					end
				end
				ST_M_CMP: begin
					if ({ramp_d_q, 1'b0} >= {1'b0, total_q}) begin
						ramp_d_q <= {1'b0, total_q[POS_W-1:1]};
						coast_d_q <= '0;
						coast_t_q <= '0;
						second_q <= 1'b1;
						state_q <= ST_M_MUL3;
					end else begin
						coast_d_q <= total_q - {ramp_d_q[POS_W-2:0], 1'b0};
						if (peak_q == '0) begin
							coast_t_q <= '1;
							state_q <= ST_M_WHOLE;
						end else begin
							div_start_q <= 1'b1;
							state_q <= ST_DV_CT;
						end
					end
				end
				ST_M_MUL3: begin
					prod_q <= product;
					sq_start_q <= 1'b1;
					state_q <= ST_M_SQ;
				end
				ST_DV_CT: begin
					if (div_done) begin
						coast_t_q <= div_sat;
						state_q <= ST_M_WHOLE;
					end
				end
				ST_M_WHOLE: begin
					whole_t_q <= (|whole_sum[POS_W+1:POS_W]) ? '1 : whole_sum[POS_W-1:0];
					done_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_T_PH: begin
					if (e_q == '0) begin
						d_q <= '0;
						state_q <= ST_T_FIN;
					end else if (e_q >= {1'b0, whole_t_q}) begin
						d_q <= total_q;
						state_q <= ST_T_FIN;
					end else if (e_q < {1'b0, ramp_t_q}) begin
						phase_q <= PH_ACC;
						x_q <= e_q[POS_W-1:0];
						state_q <= ST_T_HA1;
					end else if (e_after_ramp < {1'b0, coast_t_q}) begin
						phase_q <= PH_CRU;
						x_q <= e_after_ramp[POS_W-1:0];
						state_q <= ST_T_VT;
					end else begin
						phase_q <= PH_DEC;
						x_q <= e_after_ramp[POS_W-1:0] - coast_t_q;
						state_q <= ST_T_VT;
					end
				end
				ST_T_VT: begin
					vt_q <= product[63:16];
					state_q <= (phase_q == PH_CRU) ? ST_T_POS : ST_T_HA1;
				end
				ST_T_HA1: begin
					v_q <= (|product[63:48]) ? '1 : product[47:16];
					state_q <= ST_T_HA2;
				end
				ST_T_HA2: begin
					h_q <= product[63:17];
					state_q <= ST_T_POS;
				end
				ST_T_POS: begin
					if (pos < 0) begin
						d_q <= '0;
					end else if (pos > $signed(51'(total_q))) begin
						d_q <= total_q;
					end else begin
						d_q <= pos[POS_W-1:0];
					end
					state_q <= ST_T_FIN;
				end
				ST_T_FIN: begin
					if (e_q >= {1'b0, whole_t_q} || d_q >= total_q) begin
						present_q <= goal_q;
						done_q <= 1'b1;
					end else begin
						present_q <= neg_q ? origin_q - d_q : origin_q + d_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign current_position = present_q;
	assign target_now = goal_q;
	assign finished = done_q;

endmodule

/* tb/sv/tb_trapezoidal_motion_profile_unit.sv */
// Testbench for the trapezoidal motion profile unit: predicted profile checked per transaction.
`timescale 1ns / 1ps

module tb_trapezoidal_motion_profile_unit;
	import tmp_pkg::*;

	class profile_scoreboard;
		bit [31:0] vel_lim, acc_lim;
		bit [31:0] origin, goal, present, elapsed, span, ramp_d, coast_d, peak, ramp_t,
			coast_t, whole_t;
		bit neg, done;
		bit [31:0] exp_pos[$], exp_tgt[$];
		bit exp_fin[$];
		int errors;

		function void clear();
			vel_lim = MAX_VEL_RESET; acc_lim = MAX_ACC_RESET;
			origin = 0; goal = 0; present = 0; elapsed = 0; span = 0; ramp_d = 0;
			coast_d = 0; peak = 0; ramp_t = 0; coast_t = 0; whole_t = 0;
			neg = 0; done = 1; errors = 0;
		endfunction

		function void set_limit(bit idx, bit [30:0] val);
			bit [31:0] v;
			v = (val < MIN_LIMIT) ? MIN_LIMIT : val;
			if (idx == REG_MAX_VEL) vel_lim = v; else acc_lim = v;
		endfunction

		function bit [63:0] root(bit [63:0] x);
			bit [63:0] r, b;
			r = 0; b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin x -= r + b; r = (r >> 1) + b; end
				else r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function bit [31:0] sat(bit [63:0] v);
			return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
		endfunction

		function bit [31:0] tquot(bit [63:0] num, bit [31:0] den);
			if (den == 0) return 32'hFFFFFFFF;
			return sat((num << 16) / den);
		endfunction

		function bit [63:0] half_acc(bit [63:0] e);
			bit [63:0] v;
			v = (acc_lim * e) >> 16;
			if (v > 64'hFFFFFFFF) v = 64'hFFFFFFFF;
			return (v * e) >> 17;
		endfunction

		function bit [63:0] travel(bit [63:0] e);
			longint p;
			if (e == 0) return 0;
			if (e >= whole_t) return span;
			if (e < ramp_t) p = half_acc(e);
			else begin
				e -= ramp_t;
				if (e < coast_t) p = ramp_d + ((peak * e) >> 16);
				else begin
					e -= coast_t;
					p = longint'(ramp_d) + coast_d + ((peak * e) >> 16) - half_acc(e);
				end
			end
			if (p < 0) p = 0;
			if (p > span) p = span;
			return p;
		endfunction

		function void note_input(bit c, bit [31:0] s, bit [31:0] t);
			longint diff, p;
			bit [63:0] tri_v, e, d;
			if (c == CMD_MOVE) begin
				diff = longint'(signed'(t)) - longint'(signed'(s));
				origin = s; goal = t; present = s; elapsed = 0;
				neg = diff < 0; span = (diff < 0) ? -diff : diff;
				if (span < MIN_LIMIT) begin
					ramp_d = 0; coast_d = 0; peak = 0; ramp_t = 0; coast_t = 0; whole_t = 0;
					present = goal; done = 1;
				end else begin
					tri_v = root(64'(span) * acc_lim);
					peak = (tri_v < vel_lim) ? tri_v[31:0] : vel_lim;
					ramp_t = tquot(peak, acc_lim);
					ramp_d = sat((64'(peak) * peak) / (64'(acc_lim) * 2));
					if (64'(ramp_d) * 2 >= span) begin
						ramp_d = span >> 1; coast_d = 0;
						peak = sat(root(64'(acc_lim) * 2 * ramp_d));
						ramp_t = tquot(peak, acc_lim); coast_t = 0;
					end else begin
						coast_d = span - 2 * ramp_d;
						coast_t = tquot(coast_d, peak);
					end
					whole_t = sat(64'(ramp_t) * 2 + coast_t);
					done = 0;
				end
			end else begin
				elapsed = sat(64'(elapsed) + TICK_MS);
				if (!done) begin
					e = (64'(elapsed) << 16) / MS_PER_S;
					d = travel(e);
					p = longint'(signed'(origin));
					p = neg ? p - longint'(d) : p + longint'(d);
					present = p[31:0];
					if (e >= whole_t || d >= span) begin present = goal; done = 1; end
				end
			end
			exp_pos.push_back(present); exp_tgt.push_back(goal); exp_fin.push_back(done);
		endfunction

		function void check_result(bit [31:0] pos, bit [31:0] tgt, bit fin);
			if (exp_pos.size() == 0) begin
				$display("%0t unexpected result pos %h", $time, pos);
				errors++;
				return;
			end
			if (pos !== exp_pos[0]) begin
				$display("%0t current_position exp %h got %h", $time, exp_pos[0], pos);
				errors++;
			end
			if (tgt !== exp_tgt[0]) begin
				$display("%0t target_now exp %h got %h", $time, exp_tgt[0], tgt);
				errors++;
			end
			if (fin !== exp_fin[0]) begin
				$display("%0t finished exp %b got %b", $time, exp_fin[0], fin);
				errors++;
			end
			void'(exp_pos.pop_front()); void'(exp_tgt.pop_front()); void'(exp_fin.pop_front());
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, cmd = 0, out_ready = 0, cfg_wr_en = 0, cfg_index = 0;
	logic [31:0] start_position = 0, target_position = 0;
	logic [30:0] cfg_data = 0;
	logic in_ready, out_valid, finished;
	logic [31:0] current_position, target_now;
	int send_idle = 0, recv_stall = 0;
	longint cycles = 0;
	profile_scoreboard board;

	trapezoidal_motion_profile_unit u_dut (.*);

	always begin #2 clk = 1; #2 clk = 0; end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 40000000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(current_position, target_now, finished);
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send_item(bit c, bit [31:0] s, bit [31:0] t);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; cmd <= c; start_position <= s; target_position <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(c, s, t);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.exp_pos.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_limit(bit idx, bit [31:0] val);
		cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val[30:0];
		@(posedge clk);
		board.set_limit(idx, val[30:0]);
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	function automatic bit [31:0] rand_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(2000) - 1000;
			default: return ($urandom_range(600000) - 300000);
		endcase
	endfunction

	task automatic run_move(int ticks);
		bit [31:0] s;
		s = rand_pos();
		send_item(CMD_MOVE, s, s + $urandom_range(400000) - 200000);
		repeat (ticks) send_item(CMD_TICK, $urandom, $urandom);
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_item(CMD_TICK, 0, 0);
		send_item(CMD_MOVE, 32'h7FFFFFFF, 32'h80000000);
		send_item(CMD_TICK, 0, 0);
		send_item(CMD_MOVE, 32'h80000000, 32'h7FFFFFFF);
		send_item(CMD_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(CMD_MOVE, 100, 165);
		send_item(CMD_TICK, 0, 0);
		send_item(CMD_MOVE, 100, 166);
		repeat (3) send_item(CMD_TICK, 0, 0);
		send_item(CMD_MOVE, 0, 32'hFFFF0000);
		repeat (6) send_item(CMD_TICK, 0, 0);
		send_item(CMD_MOVE, 0, 32'd2000);
		repeat (5) send_item(CMD_TICK, 0, 0);
		drain();
		write_limit(REG_MAX_VEL, 32'd0);
		write_limit(REG_MAX_ACC, 32'h7FFFFFFF);
		run_move(10);
		drain();
		write_limit(REG_MAX_VEL, 32'h7FFFFFFF);
		write_limit(REG_MAX_ACC, 32'd0);
		run_move(10);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 48; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 48; end
				default: begin send_idle = 14; recv_stall = 14; end
			endcase
			write_limit(REG_MAX_VEL, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000, 66));
			write_limit(REG_MAX_ACC, $urandom_range(3) == 0 ? $urandom : $urandom_range(30000000, 66));
			for (int m = 0; m < 5; m++) begin
				if ($urandom_range(5) == 0) send_item(CMD_TICK, $urandom, $urandom);
				run_move($urandom_range(30));
			end
			if (ph == 3) begin
				drain();
				send_item(CMD_TICK, 0, 0);
			end
			drain();
		end
		send_idle = 0; recv_stall = 0;
		write_limit(REG_MAX_VEL, {1'b0, MAX_VEL_RESET});
		write_limit(REG_MAX_ACC, {1'b0, MAX_ACC_RESET});
		send_item(CMD_MOVE, 0, 32'd6554);
		repeat (120) send_item(CMD_TICK, 0, 0);
		drain();
		if (board.errors == 0 && board.exp_pos.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
